FILE: rtl/opts_pkg.sv
package opts_pkg;

  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 3;
  localparam int MASK_W     = 8;
  localparam int FAST_W     = 4;
  localparam int SLOW_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // operation codes of an input item
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_REG   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNREG = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_DIVIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIVIDE  = 2'd2;

  localparam logic [TIME_W-1:0] BOOT_TIMEOUT_RST = 32'd10000;
  localparam logic [FAST_W-1:0] FAST_DIVIDE_RST  = 4'd10;
  localparam logic [SLOW_W-1:0] SLOW_DIVIDE_RST  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_REG,
    ST_UNREG,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/opts_if.sv
interface opts_in_if;
  logic                           valid;
  logic                           ready;
  logic [opts_pkg::OP_W-1:0]      op;
  logic                           repeat_mode;
  logic [opts_pkg::DELAY_W-1:0]   first_delay;
  logic [opts_pkg::PERIOD_W-1:0]  repeat_period;
  logic [opts_pkg::IDX_W-1:0]     slot_index;

  modport source (output valid, op, repeat_mode, first_delay, repeat_period, slot_index,
                  input ready);
  modport sink   (input valid, op, repeat_mode, first_delay, repeat_period, slot_index,
                  output ready);
endinterface

interface opts_out_if;
  logic                          valid;
  logic                          ready;
  logic [opts_pkg::MASK_W-1:0]   fired_mask;
  logic                          scan_done;
  logic                          frame_pulse;
  logic                          slow_frame_pulse;
  logic                          boot_active;
  logic                          reg_ok;
  logic [opts_pkg::IDX_W-1:0]    reg_slot;
  logic [opts_pkg::TIME_W-1:0]   time_now;

  modport source (output valid, fired_mask, scan_done, frame_pulse, slow_frame_pulse,
                         boot_active, reg_ok, reg_slot, time_now,
                  input ready);
  modport sink   (input valid, fired_mask, scan_done, frame_pulse, slow_frame_pulse,
                        boot_active, reg_ok, reg_slot, time_now,
                  output ready);
endinterface

FILE: rtl/opts_slot_mem.sv
module opts_slot_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 48
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/opts_calc.sv
module opts_calc (
  input  logic [opts_pkg::TIME_W-1:0]   now_i,
  input  logic [opts_pkg::TIME_W-1:0]   due_i,
  input  logic [opts_pkg::PERIOD_W-1:0] addend_i,
  output logic                          reached_o,
  output logic [opts_pkg::TIME_W-1:0]   sum_o
);

  import opts_pkg::*;

  logic [TIME_W-1:0] diff;

  // wrap-safe: due is reached when (now - due) is non-negative as a signed value
  assign diff      = now_i - due_i;
  assign reached_o = ~diff[TIME_W-1];
  assign sum_o     = now_i + TIME_W'(addend_i);

endmodule

FILE: rtl/oneshot_periodic_timer_slots.sv
// Bank of SLOTS timer slots driven by tick, register and unregister transactions; one result
// per transaction. The slot due times and periods sit in a memory with one read and one write
// port, both walked by one slot pointer, through a shared add/compare unit. A tick updates the
// time and frame counters and, when it scans, reads every slot in turn and evaluates each
// active one; a register transaction walks the slots from the lowest until it finds a free one
// or reaches the last; unregister clears one slot and an unused opcode only returns a result.
// The input is not ready while a transaction is being worked on; a finished result waits in
// the output register, so the next transaction may be accepted before it is taken. No clearing
// pass is needed after reset.
module oneshot_periodic_timer_slots #(
  parameter int SLOTS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [opts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [opts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  opts_in_if.sink                          in_i,
  opts_out_if.source                       out_o
);

  import opts_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W  = PERIOD_W + TIME_W;

  state_e state_q, state_d;

  logic [TIME_W-1:0]   boot_timeout_q;
  logic [FAST_W-1:0]   fast_div_q;
  logic [SLOW_W-1:0]   slow_div_q;

  logic                rep_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [PERIOD_W-1:0] period_q;
  logic [IDX_W-1:0]    idx_q;

  logic [TIME_W-1:0]   tick_q;
  logic                boot_q;
  logic [FAST_W-1:0]   sub_q;
  logic [SLOW_W-1:0]   frame_q;
  logic [SLOTS-1:0]    active_q;
  logic [SLOTS-1:0]    repeat_q;
  logic [SLOT_W-1:0]   ptr_q;

  logic [MASK_W-1:0]   fired_q;
  logic                scan_q;
  logic                fp_q;
  logic                sp_q;
  logic                ok_q;
  logic [IDX_W-1:0]    slot_q;

  logic                out_valid_q;
  logic [MASK_W-1:0]   out_fired_q;
  logic                out_scan_q;
  logic                out_fp_q;
  logic                out_sp_q;
  logic                out_boot_q;
  logic                out_ok_q;
  logic [IDX_W-1:0]    out_slot_q;
  logic [TIME_W-1:0]   out_time_q;

  logic                accept;
  logic                last;
  logic                load;
  logic                cur_active;
  logic [TIME_W-1:0]   tick_next;
  logic                boot_next;
  logic [FAST_W-1:0]   sub_next;
  logic [SLOW_W-1:0]   frame_next;
  logic                frame_hit;
  logic                slow_hit;
  logic                scan_need;

  logic                mem_we;
  logic [ENT_W-1:0]    mem_wdata;
  logic [ENT_W-1:0]    mem_rdata;
  logic [PERIOD_W-1:0] rd_period;
  logic [TIME_W-1:0]   rd_due;
  logic [PERIOD_W-1:0] calc_addend;
  logic                reached;
  logic [TIME_W-1:0]   calc_sum;
  logic                reload;
  logic                unreg_hit;

  assign accept     = in_i.valid && in_i.ready;
  assign last       = (ptr_q == SLOT_W'(SLOTS - 1));
  assign load       = !out_valid_q || out_o.ready;
  assign cur_active = active_q[ptr_q];
  assign rd_period  = mem_rdata[ENT_W-1:TIME_W];
  assign rd_due     = mem_rdata[TIME_W-1:0];
  assign reload     = repeat_q[ptr_q] && (rd_period != '0);
  assign unreg_hit  = (32'(idx_q) < SLOTS);

  // tick bookkeeping, evaluated in the tick state
  assign tick_next  = tick_q + TIME_W'(1);
  assign boot_next  = boot_q && !(tick_next > boot_timeout_q);
  assign sub_next   = sub_q + FAST_W'(1);
  assign frame_hit  = (sub_next >= fast_div_q);
  assign frame_next = frame_q + SLOW_W'(1);
  assign slow_hit   = frame_hit && (frame_next >= slow_div_q);
  assign scan_need  = boot_next || frame_hit;

  opts_slot_mem #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ptr_q),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  opts_calc u_calc (
    .now_i     (tick_q),
    .due_i     (rd_due),
    .addend_i  (calc_addend),
    .reached_o (reached),
    .sum_o     (calc_sum)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.op)
            OP_TICK:  state_d = ST_TICK;
            OP_REG:   state_d = ST_REG;
            OP_UNREG: state_d = ST_UNREG;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      ST_TICK:    state_d = scan_need ? ST_SCAN_RD : ST_OUT;
      ST_REG: begin
        if (!cur_active || last) state_d = ST_OUT;
      end
      ST_UNREG:   state_d = ST_OUT;
      ST_SCAN_RD: begin
        if (cur_active) begin
          state_d = ST_SCAN_EV;
        end else if (last) begin
          state_d = ST_OUT;
        end
      end
      ST_SCAN_EV: state_d = last ? ST_OUT : ST_SCAN_RD;
      ST_OUT: begin
        if (load) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    mem_we      = 1'b0;
    calc_addend = rd_period;
    mem_wdata   = {rd_period, calc_sum};
    unique case (state_q)
      ST_REG: begin
        calc_addend = delay_q;
        mem_we      = !cur_active;
        mem_wdata   = {(rep_q ? period_q : '0), calc_sum};
      end
      ST_SCAN_EV: begin
        mem_we = reached && reload;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      boot_timeout_q <= BOOT_TIMEOUT_RST;
      fast_div_q     <= FAST_DIVIDE_RST;
      slow_div_q     <= SLOW_DIVIDE_RST;
      tick_q         <= '0;
      boot_q         <= 1'b1;
      sub_q          <= '0;
      frame_q        <= '0;
      active_q       <= '0;
      repeat_q       <= '0;
      ptr_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BOOT_TIMEOUT: boot_timeout_q <= cfg_data_i[TIME_W-1:0];
          CFG_FAST_DIVIDE:  fast_div_q     <= cfg_data_i[FAST_W-1:0];
          CFG_SLOW_DIVIDE:  slow_div_q     <= cfg_data_i[SLOW_W-1:0];
          default:          ;
        endcase
      end

      if ((state_q == ST_OUT) && load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          ptr_q <= '0;
        end
        ST_TICK: begin
          tick_q <= tick_next;
          boot_q <= boot_next;
          sub_q  <= frame_hit ? '0 : sub_next;
          if (frame_hit) frame_q <= slow_hit ? '0 : frame_next;
        end
        ST_REG: begin
          if (!cur_active) begin
            active_q[ptr_q] <= 1'b1;
            repeat_q[ptr_q] <= rep_q;
          end else if (!last) begin
            ptr_q <= ptr_q + SLOT_W'(1);
          end
        end
        ST_UNREG: begin
          if (unreg_hit) active_q[SLOT_W'(idx_q)] <= 1'b0;
        end
        ST_SCAN_RD: begin
          if (!cur_active && !last) ptr_q <= ptr_q + SLOT_W'(1);
        end
        ST_SCAN_EV: begin
          // free a fired slot that does not reload
          if (reached && !reload) active_q[ptr_q] <= 1'b0;
          if (!last) ptr_q <= ptr_q + SLOT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // transaction payload and result fields
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rep_q    <= in_i.repeat_mode;
          delay_q  <= in_i.first_delay;
          period_q <= in_i.repeat_period;
          idx_q    <= in_i.slot_index;
          fired_q  <= '0;
          scan_q   <= 1'b0;
          fp_q     <= 1'b0;
          sp_q     <= 1'b0;
          ok_q     <= 1'b0;
          slot_q   <= '0;
        end
      end
      ST_TICK: begin
        scan_q <= scan_need;
        fp_q   <= frame_hit;
        sp_q   <= slow_hit;
      end
      ST_REG: begin
        if (!cur_active) begin
          ok_q   <= 1'b1;
          slot_q <= IDX_W'(ptr_q);
        end
      end
      ST_SCAN_EV: begin
        if (reached && (32'(ptr_q) < MASK_W)) fired_q[IDX_W'(ptr_q)] <= 1'b1;
      end
      ST_OUT: begin
        if (load) begin
          out_fired_q <= fired_q;
          out_scan_q  <= scan_q;
          out_fp_q    <= fp_q;
          out_sp_q    <= sp_q;
          out_boot_q  <= boot_q;
          out_ok_q    <= ok_q;
          out_slot_q  <= slot_q;
          out_time_q  <= tick_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.fired_mask       = out_fired_q;
  assign out_o.scan_done        = out_scan_q;
  assign out_o.frame_pulse      = out_fp_q;
  assign out_o.slow_frame_pulse = out_sp_q;
  assign out_o.boot_active      = out_boot_q;
  assign out_o.reg_ok           = out_ok_q;
  assign out_o.reg_slot         = out_slot_q;
  assign out_o.time_now         = out_time_q;

endmodule

FILE: verif/oneshot_periodic_timer_slots_test.sv
`timescale 1ns / 1ps

module oneshot_periodic_timer_slots_test;
  import opts_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_CYCLES  = 40;

  // opcode that the block must treat as a no-op
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                repeat_mode;
    logic [DELAY_W-1:0]  first_delay;
    logic [PERIOD_W-1:0] repeat_period;
    logic [IDX_W-1:0]    slot_index;
  } timer_txn_t;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic              scan_done;
    logic              frame_pulse;
    logic              slow_frame_pulse;
    logic              boot_active;
    logic              reg_ok;
    logic [IDX_W-1:0]  reg_slot;
    logic [TIME_W-1:0] time_now;
  } timer_result_t;

  localparam timer_txn_t TICK_TXN = '{op: OP_TICK, default: '0};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  opts_in_if  in_if ();
  opts_out_if out_if ();

  oneshot_periodic_timer_slots #(
    .SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // scheduler state as predicted
  logic [TIME_W-1:0]   now_ticks;
  logic                in_boot;
  logic [FAST_W-1:0]   frame_sub;
  logic [SLOW_W-1:0]   frame_cnt;
  logic                slot_busy   [NUM_SLOTS];
  logic                slot_rep    [NUM_SLOTS];
  logic [TIME_W-1:0]   slot_due_at [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_reload [NUM_SLOTS];

  logic [TIME_W-1:0] boot_limit;
  logic [FAST_W-1:0] fast_div;
  logic [SLOW_W-1:0] slow_div;

  timer_result_t pending_results[$];
  int            failures      = 0;
  int            src_idle_pct  = 0;
  int            snk_idle_pct  = 0;
  int            hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [MASK_W-1:0] fire_due_slots();
    logic [MASK_W-1:0] fired;
    logic [TIME_W-1:0] lag;
    fired = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      // wrap-safe: due is reached while now - due stays non-negative
      lag = now_ticks - slot_due_at[s];
      if (slot_busy[s] && !lag[TIME_W-1]) begin
        fired[s] = 1'b1;
        if (!slot_rep[s] || slot_reload[s] == '0) slot_busy[s] = 1'b0;
        else slot_due_at[s] = now_ticks + slot_reload[s];
      end
    end
    return fired;
  endfunction

  function automatic timer_result_t predict_timer_result(timer_txn_t t);
    timer_result_t r;
    r = '0;
    case (t.op)
      OP_TICK: begin
        now_ticks = now_ticks + 1'b1;
        if (in_boot && now_ticks > boot_limit) in_boot = 1'b0;
        if (in_boot) begin
          r.fired_mask |= fire_due_slots();
          r.scan_done = 1'b1;
        end
        frame_sub = frame_sub + 1'b1;
        if (frame_sub >= fast_div) begin
          frame_sub     = '0;
          r.frame_pulse = 1'b1;
          if (!in_boot) begin
            r.fired_mask |= fire_due_slots();
            r.scan_done = 1'b1;
          end
          frame_cnt = frame_cnt + 1'b1;
          if (frame_cnt >= slow_div) begin
            frame_cnt          = '0;
            r.slow_frame_pulse = 1'b1;
          end
        end
      end
      OP_REG: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!slot_busy[s] && !r.reg_ok) begin
            slot_busy[s]   = 1'b1;
            slot_rep[s]    = t.repeat_mode;
            slot_due_at[s] = now_ticks + t.first_delay;
            slot_reload[s] = t.repeat_mode ? t.repeat_period : '0;
            r.reg_ok       = 1'b1;
            r.reg_slot     = IDX_W'(s);
          end
        end
      end
      OP_UNREG: slot_busy[t.slot_index] = 1'b0;
      default: ;
    endcase
    r.boot_active = in_boot;
    r.time_now    = now_ticks;
    return r;
  endfunction

  function automatic timer_txn_t make_txn(logic [OP_W-1:0] op, logic rep,
                                          logic [DELAY_W-1:0] delay,
                                          logic [PERIOD_W-1:0] period,
                                          logic [IDX_W-1:0] idx);
    timer_txn_t t;
    t.op            = op;
    t.repeat_mode   = rep;
    t.first_delay   = delay;
    t.repeat_period = period;
    t.slot_index    = idx;
    return t;
  endfunction

  function automatic timer_txn_t random_timer_txn();
    timer_txn_t t;
    int         pick;
    t.repeat_mode = 1'($urandom_range(1));
    t.slot_index  = IDX_W'($urandom_range(NUM_SLOTS - 1));
    pick = $urandom_range(99);
    if (pick < 55)      t.op = OP_TICK;
    else if (pick < 80) t.op = OP_REG;
    else if (pick < 95) t.op = OP_UNREG;
    else                t.op = OP_SPARE;
    // keep most delays short so slots come due within the run
    pick = $urandom_range(99);
    if (pick < 70)      t.first_delay = DELAY_W'($urandom_range(40));
    else if (pick < 85) t.first_delay = DELAY_W'($urandom_range(400));
    else                t.first_delay = DELAY_W'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 20)      t.repeat_period = '0;
    else if (pick < 80) t.repeat_period = PERIOD_W'($urandom_range(40, 1));
    else                t.repeat_period = PERIOD_W'($urandom_range(65535));
    return t;
  endfunction

  task automatic send_timer_txn(timer_txn_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= t.op;
    in_if.repeat_mode   <= t.repeat_mode;
    in_if.first_delay   <= t.first_delay;
    in_if.repeat_period <= t.repeat_period;
    in_if.slot_index    <= t.slot_index;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_timer_result(t));
  endtask

  // hold the input until every outstanding transaction has returned
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_timer_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BOOT_TIMEOUT: boot_limit = data;
      CFG_FAST_DIVIDE:  fast_div   = data[FAST_W-1:0];
      CFG_SLOW_DIVIDE:  slow_div   = data[SLOW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      failures++;
    end
  endtask

  initial begin : result_checker
    int            hold_left;
    int            hold_seen;
    timer_result_t want;
    timer_result_t got;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.fired_mask       = out_if.fired_mask;
        got.scan_done        = out_if.scan_done;
        got.frame_pulse      = out_if.frame_pulse;
        got.slow_frame_pulse = out_if.slow_frame_pulse;
        got.boot_active      = out_if.boot_active;
        got.reg_ok           = out_if.reg_ok;
        got.reg_slot         = out_if.reg_slot;
        got.time_now         = out_if.time_now;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("fired_mask", TIME_W'(want.fired_mask), TIME_W'(got.fired_mask));
          check_field("scan_done", TIME_W'(want.scan_done), TIME_W'(got.scan_done));
          check_field("frame_pulse", TIME_W'(want.frame_pulse), TIME_W'(got.frame_pulse));
          check_field("slow_frame_pulse", TIME_W'(want.slow_frame_pulse),
                      TIME_W'(got.slow_frame_pulse));
          check_field("boot_active", TIME_W'(want.boot_active), TIME_W'(got.boot_active));
          check_field("reg_ok", TIME_W'(want.reg_ok), TIME_W'(got.reg_ok));
          check_field("reg_slot", TIME_W'(want.reg_slot), TIME_W'(got.reg_slot));
          check_field("time_now", want.time_now, got.time_now);
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic test_directed_slots();
    send_timer_txn(make_txn(OP_REG, 1'b0, '0, '1, '0));
    send_timer_txn(make_txn(OP_REG, 1'b1, 16'd1, 16'd1, '0));
    // repeating slot with no period stops after its first firing
    send_timer_txn(make_txn(OP_REG, 1'b1, 16'd2, '0, '0));
    send_timer_txn(make_txn(OP_REG, 1'b1, '1, '1, '1));
    repeat (2) send_timer_txn(TICK_TXN);
    send_timer_txn(make_txn(OP_SPARE, 1'b1, '1, '1, '1));
    repeat (6) send_timer_txn(make_txn(OP_REG, 1'b0, 16'd3, '0, '1));
    // bank is full now: the transaction must be refused
    send_timer_txn(make_txn(OP_REG, 1'b1, 16'd1, 16'd1, '0));
    send_timer_txn(make_txn(OP_UNREG, 1'b0, '0, '0, 3'd7));
    send_timer_txn(make_txn(OP_UNREG, 1'b1, '1, '1, 3'd0));
    send_timer_txn(make_txn(OP_UNREG, 1'b0, '0, '0, 3'd0));
    send_timer_txn(make_txn(OP_REG, 1'b1, 16'd5, '0, '0));
    repeat (6) send_timer_txn(TICK_TXN);
  endtask

  task automatic test_divider_settings();
    wait_results_drained();
    write_timer_reg(CFG_BOOT_TIMEOUT, '1);
    write_timer_reg(CFG_FAST_DIVIDE, 32'd1);
    write_timer_reg(CFG_SLOW_DIVIDE, 32'd7);
    repeat (10) send_timer_txn(TICK_TXN);
    wait_results_drained();
    write_timer_reg(CFG_FAST_DIVIDE, 32'd15);
    write_timer_reg(CFG_SLOW_DIVIDE, 32'd1);
    repeat (8) send_timer_txn(TICK_TXN);
    // lower the divider below the running count: frame must end on the next tick
    wait_results_drained();
    write_timer_reg(CFG_FAST_DIVIDE, 32'd3);
    repeat (4) send_timer_txn(TICK_TXN);
    wait_results_drained();
    write_timer_reg(CFG_FAST_DIVIDE, 32'd1);
    write_timer_reg(CFG_SLOW_DIVIDE, 32'd7);
    repeat (5) send_timer_txn(TICK_TXN);
    wait_results_drained();
    write_timer_reg(CFG_SLOW_DIVIDE, 32'd2);
    repeat (3) send_timer_txn(TICK_TXN);
    wait_results_drained();
    write_timer_reg(CFG_FAST_DIVIDE, 32'd0);
    write_timer_reg(CFG_SLOW_DIVIDE, 32'd0);
    repeat (4) send_timer_txn(TICK_TXN);
  endtask

  task automatic test_backpressure();
    int keep_idle;
    keep_idle    = src_idle_pct;
    src_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (12) send_timer_txn(random_timer_txn());
    src_idle_pct = keep_idle;
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int items, logic [FAST_W-1:0] fast,
                                     logic [SLOW_W-1:0] slow);
    wait_results_drained();
    write_timer_reg(CFG_FAST_DIVIDE, CFG_DATA_W'(fast));
    write_timer_reg(CFG_SLOW_DIVIDE, CFG_DATA_W'(slow));
    repeat (items) begin
      send_timer_txn(random_timer_txn());
      if ($urandom_range(49) == 0) wait_results_drained();
    end
  endtask

  task automatic test_boot_exit();
    wait_results_drained();
    write_timer_reg(CFG_BOOT_TIMEOUT, now_ticks + 12);
    write_timer_reg(CFG_FAST_DIVIDE, 32'd4);
    write_timer_reg(CFG_SLOW_DIVIDE, 32'd3);
    while (in_boot) send_timer_txn(random_timer_txn());
    repeat (10) send_timer_txn(random_timer_txn());
    // boot mode is over for good, so a zero timeout changes nothing
    wait_results_drained();
    write_timer_reg(CFG_BOOT_TIMEOUT, '0);
  endtask

  initial begin : stimulus
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_BOOT_TIMEOUT;
    cfg_data_i          <= '0;
    in_if.valid         <= 1'b0;
    in_if.op            <= OP_TICK;
    in_if.repeat_mode   <= 1'b0;
    in_if.first_delay   <= '0;
    in_if.repeat_period <= '0;
    in_if.slot_index    <= '0;

    now_ticks  = '0;
    in_boot    = 1'b1;
    frame_sub  = '0;
    frame_cnt  = '0;
    boot_limit = BOOT_TIMEOUT_RST;
    fast_div   = FAST_DIVIDE_RST;
    slow_div   = SLOW_DIVIDE_RST;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_busy[s]   = 1'b0;
      slot_rep[s]    = 1'b0;
      slot_due_at[s] = '0;
      slot_reload[s] = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 26;
    snk_idle_pct = 58;
    test_directed_slots();
    test_divider_settings();
    test_backpressure();
    test_random_traffic(100, 4'd7, 3'd3);
    test_boot_exit();

    src_idle_pct = 58;
    snk_idle_pct = 26;
    test_random_traffic(100, 4'd2, 3'd7);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(100, 4'd1, 3'd1);

    wait_results_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: oneshot_periodic_timer_slots.f
rtl/opts_pkg.sv
rtl/opts_if.sv
rtl/opts_slot_mem.sv
rtl/opts_calc.sv
rtl/oneshot_periodic_timer_slots.sv
verif/oneshot_periodic_timer_slots_test.sv
